// ----- rtl/sle_pkg.sv -----
// Package for the sprite line evaluator: sizes, mode limits, FSM states and
// the packed sprite and cell records shared by the core and the cell unit.
// No dependencies.
package sle_pkg;

  localparam int unsigned MaxSpritesDef = 80;
  localparam int unsigned MaxCellsDef   = 40;

  localparam int unsigned SprWide    = 80;
  localparam int unsigned SprNarrow  = 64;
  localparam int unsigned CellWide   = 40;
  localparam int unsigned CellNarrow = 32;
  localparam logic [4:0]  PerLineWide   = 5'd20;
  localparam logic [4:0]  PerLineNarrow = 5'd16;

  // Screen Y and X are stored with an offset of 128.
  localparam logic [8:0] CoordOffset = 9'd128;
  // Minus 128 in ten bits, for the cell X output.
  localparam logic [9:0] XBias = 10'd896;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EVAL,
    S_CELL,
    S_FIN,
    S_ORD,
    S_OUT
  } sle_state_e;

  typedef struct packed {
    logic [10:0] tile;
    logic [8:0]  raw_x;
    logic [1:0]  pal;
    logic [1:0]  vc_m1;
    logic [1:0]  hc_m1;
    logic [1:0]  crow;
    logic [2:0]  prow;
    logic        hflip;
  } sle_sprite_t;

  typedef struct packed {
    logic [11:0] tile_index;
    logic [9:0]  cell_x;
    logic [1:0]  palette;
    logic [2:0]  pixel_row;
    logic        hflip;
  } sle_cell_t;

endpackage

// ----- rtl/sprite_line_evaluator_unit.sv -----
// Sprite line evaluator top level: sequencer, sprite table, cell buffer.
// Walks the linked sprite list one entry at a time (read, then evaluate), expanding each unmasked hit one cell a cycle.
// Sequence: a write is taken from idle; an evaluation is accepted, then each visited
// entry is read and evaluated, each cell written (with a final check when the cell limit is
// hit), the line finished, and each result fetched and then held until out_ready_i.
// The block takes one transaction at a time; the list walk and result drain set the pace.
// After reset a clearing pass writes zero to every table entry, with
// in_ready_o low; configuration writes are taken throughout.
module sprite_line_evaluator_unit #(
  parameter int unsigned MAX_SPRITES = sle_pkg::MaxSpritesDef,
  parameter int unsigned MAX_CELLS   = sle_pkg::MaxCellsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [6:0]  entry_index_i,
  input  logic [63:0] entry_data_i,
  input  logic [7:0]  line_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        has_cell_o,
  output logic [11:0] tile_index_o,
  output logic signed [9:0] cell_x_o,
  output logic [1:0]  palette_o,
  output logic [2:0]  pixel_row_o,
  output logic        hflip_o,
  output logic        dot_overflow_o,
  output logic        last_o
);
  import sle_pkg::*;

  localparam int unsigned SAW = $clog2(MAX_SPRITES);
  localparam int unsigned SCW = $clog2(MAX_SPRITES + 1);
  localparam int unsigned CAW = $clog2(MAX_CELLS);
  localparam int unsigned CCW = $clog2(MAX_CELLS + 1);
  localparam int unsigned SprW = (MAX_SPRITES < SprWide) ? MAX_SPRITES : SprWide;
  localparam int unsigned CellW = (MAX_CELLS < CellWide) ? MAX_CELLS : CellWide;

  sle_state_e state_q, state_d;
  logic       h40_q;
  logic       prev_ovf_q, prev_ovf_d;
  logic [7:0] line_q, line_d;
  logic       prev_q, prev_d;
  logic [SAW-1:0] idx_q, idx_d, clr_q, clr_d;
  logic [SCW-1:0] scnt_q, scnt_d;
  logic [6:0] link_q, link_d;
  logic [4:0] nspr_q, nspr_d;
  logic [CCW-1:0] ncell_q, ncell_d, ptr_q, ptr_d;
  logic       ovf_q, ovf_d, mask_q, mask_d, nonmask_q, nonmask_d;
  logic [1:0] col_q, col_d;
  logic       empty_q, empty_d;
  sle_sprite_t spr_q, spr_d;

  // sprite table port
  logic           st_we;
  logic [SAW-1:0] st_waddr;
  logic [63:0]    st_wdata, st_rdata;
  // cell buffer port
  logic           cb_we;
  sle_cell_t      calc_cell, cb_rdata;

  logic [SCW-1:0] spr_count;
  logic [CCW-1:0] max_cells;
  logic [4:0]     per_line;
  logic [15:0]    w0, w1, w2, w3;
  logic [8:0]     ly, ry;
  logic [9:0]     ytop;
  logic [4:0]     srow;
  logic           hit, go_next, walk_end;
  logic [6:0]     link_sel;

  sle_ram #(.Width(64), .Depth(MAX_SPRITES)) u_sprite_table (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .raddr_i(idx_q),
    .rdata_o(st_rdata)
  );

  sle_ram #(.Width($bits(sle_cell_t)), .Depth(MAX_CELLS)) u_cell_buf (
    .clk_i  (clk_i),
    .we_i   (cb_we),
    .waddr_i(ncell_q[CAW-1:0]),
    .wdata_i(calc_cell),
    .raddr_i(ptr_q[CAW-1:0]),
    .rdata_o(cb_rdata)
  );

  sle_cell_calc u_cell_calc (
    .spr_i (spr_q),
    .col_i (col_q),
    .cell_o(calc_cell)
  );

  assign spr_count = h40_q ? SCW'(SprW) : SCW'(SprNarrow);
  assign max_cells = h40_q ? CCW'(CellW) : CCW'(CellNarrow);
  assign per_line  = h40_q ? PerLineWide : PerLineNarrow;

  assign w0 = st_rdata[63:48];
  assign w1 = st_rdata[47:32];
  assign w2 = st_rdata[31:16];
  assign w3 = st_rdata[15:0];
  assign ly   = {1'b0, line_q} + CoordOffset;
  assign ry   = w0[8:0];
  assign ytop = {1'b0, ry} + {4'd0, ({1'b0, w1[9:8]} + 3'd1), 3'd0};
  assign hit  = (ly >= ry) && ({1'b0, ly} < ytop);
  assign srow = 5'(ly - ry);

  assign link_sel = (state_q == S_EVAL) ? w1[6:0] : link_q;
  assign walk_end = (link_sel == 7'd0) || ({1'b0, link_sel} >= 8'(spr_count))
                    || ((scnt_q + SCW'(1)) >= spr_count);

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    prev_ovf_d = prev_ovf_q;
    line_d    = line_q;
    prev_d    = prev_q;
    idx_d     = idx_q;
    clr_d     = clr_q;
    scnt_d    = scnt_q;
    link_d    = link_q;
    nspr_d    = nspr_q;
    ncell_d   = ncell_q;
    ptr_d     = ptr_q;
    ovf_d     = ovf_q;
    mask_d    = mask_q;
    nonmask_d = nonmask_q;
    col_d     = col_q;
    empty_d   = empty_q;
    spr_d     = spr_q;
    st_we     = 1'b0;
    st_waddr  = clr_q;
    st_wdata  = '0;
    cb_we     = 1'b0;
    go_next   = 1'b0;
    out_valid_o = 1'b0;

    case (state_q)
      S_CLEAR: begin
        st_we = 1'b1;
        clr_d = clr_q + SAW'(1);
        if (clr_q == SAW'(MAX_SPRITES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (!cmd_i) begin
            st_waddr = entry_index_i[SAW-1:0];
            st_wdata = entry_data_i;
            st_we    = ({1'b0, entry_index_i} < 8'(MAX_SPRITES));
          end else begin
            line_d    = line_i;
            prev_d    = (line_i != 8'd0) && prev_ovf_q;
            idx_d     = '0;
            scnt_d    = '0;
            nspr_d    = '0;
            ncell_d   = '0;
            ovf_d     = 1'b0;
            mask_d    = 1'b0;
            nonmask_d = 1'b0;
            state_d   = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        link_d = w1[6:0];
        if (hit && (nspr_q >= per_line)) begin
          state_d = S_FIN;
        end else if (hit) begin
          nspr_d      = nspr_q + 5'd1;
          spr_d.tile  = w2[10:0];
          spr_d.raw_x = w3[8:0];
          spr_d.pal   = w2[14:13];
          spr_d.vc_m1 = w1[9:8];
          spr_d.hc_m1 = w1[11:10];
          spr_d.hflip = w2[11];
          spr_d.crow  = w2[12] ? (w1[9:8] - srow[4:3]) : srow[4:3];
          spr_d.prow  = w2[12] ? ~srow[2:0] : srow[2:0];
          col_d       = 2'd0;
          if (w3[8:0] == 9'd0) begin
            if (nonmask_q || prev_q) begin
              mask_d = 1'b1;
            end
            go_next = 1'b1;
          end else begin
            nonmask_d = 1'b1;
            if (mask_q || ovf_q) begin
              go_next = 1'b1;
            end else begin
              state_d = S_CELL;
            end
          end
        end else begin
          go_next = 1'b1;
        end
      end
      S_CELL: begin
        if (ncell_q >= max_cells) begin
          ovf_d   = 1'b1;
          state_d = S_FIN;
        end else begin
          cb_we   = 1'b1;
          ncell_d = ncell_q + CCW'(1);
          col_d   = col_q + 2'd1;
          if (col_q == spr_q.hc_m1) begin
            go_next = 1'b1;
          end
        end
      end
      S_FIN: begin
        prev_ovf_d = ovf_q;
        empty_d    = (ncell_q == '0);
        ptr_d      = '0;
        state_d    = S_ORD;
      end
      S_ORD: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (last_o) begin
            state_d = S_IDLE;
          end else begin
            ptr_d   = ptr_q + CCW'(1);
            state_d = S_ORD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (go_next) begin
      if (walk_end) begin
        state_d = S_FIN;
      end else begin
        scnt_d  = scnt_q + SCW'(1);
        idx_d   = link_sel[SAW-1:0];
        state_d = S_RD;
      end
    end
  end

  assign has_cell_o     = !empty_q;
  assign tile_index_o   = empty_q ? 12'd0 : cb_rdata.tile_index;
  assign cell_x_o       = empty_q ? 10'sd0 : $signed(cb_rdata.cell_x);
  assign palette_o      = empty_q ? 2'd0 : cb_rdata.palette;
  assign pixel_row_o    = empty_q ? 3'd0 : cb_rdata.pixel_row;
  assign hflip_o        = empty_q ? 1'b0 : cb_rdata.hflip;
  assign dot_overflow_o = ovf_q;
  assign last_o         = empty_q || ((ptr_q + CCW'(1)) == ncell_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      h40_q      <= 1'b0;
      prev_ovf_q <= 1'b0;
      line_q     <= '0;
      prev_q     <= 1'b0;
      idx_q      <= '0;
      clr_q      <= '0;
      scnt_q     <= '0;
      link_q     <= '0;
      nspr_q     <= '0;
      ncell_q    <= '0;
      ptr_q      <= '0;
      ovf_q      <= 1'b0;
      mask_q     <= 1'b0;
      nonmask_q  <= 1'b0;
      col_q      <= '0;
      empty_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      if (cfg_we_i) begin
        h40_q <= cfg_data_i;
      end
      prev_ovf_q <= prev_ovf_d;
      line_q     <= line_d;
      prev_q     <= prev_d;
      idx_q      <= idx_d;
      clr_q      <= clr_d;
      scnt_q     <= scnt_d;
      link_q     <= link_d;
      nspr_q     <= nspr_d;
      ncell_q    <= ncell_d;
      ptr_q      <= ptr_d;
      ovf_q      <= ovf_d;
      mask_q     <= mask_d;
      nonmask_q  <= nonmask_d;
      col_q      <= col_d;
      empty_q    <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    spr_q <= spr_d;
  end

  // A result is never shown while a new transaction could be taken.
  a_out_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("output valid while ready");

  // The cell buffer is never written beyond the line's cell limit.
  a_cell_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cb_we |-> (ncell_q < max_cells)) else $error("cell buffer overrun");

  // Non-empty results only read entries that were written on this line.
  a_rd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !empty_q) |-> (ptr_q < ncell_q)) else $error("read past cells");

  // The overflow flag only rises while cells are being expanded.
  a_ovf_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> $past(state_q == S_CELL)) else $error("stray overflow");

endmodule

// ----- rtl/sle_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module sle_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sle_cell_calc.sv -----
// Cell arithmetic unit: pattern number and screen X of one column of a sprite.
// Depends on sle_pkg.
module sle_cell_calc (
  input  sle_pkg::sle_sprite_t spr_i,
  input  logic [1:0]           col_i,
  output sle_pkg::sle_cell_t   cell_o
);
  import sle_pkg::*;

  logic [1:0] pcol;
  logic [2:0] vc;
  logic [4:0] prod;

  always_comb begin
    pcol = spr_i.hflip ? (spr_i.hc_m1 - col_i) : col_i;
    vc   = {1'b0, spr_i.vc_m1} + 3'd1;
    prod = {3'd0, pcol} * {2'd0, vc};
    cell_o.tile_index = {1'b0, spr_i.tile} + {7'd0, prod} + {10'd0, spr_i.crow};
    cell_o.cell_x     = {1'b0, spr_i.raw_x} + {5'd0, col_i, 3'd0} + XBias;
    cell_o.palette    = spr_i.pal;
    cell_o.pixel_row  = spr_i.prow;
    cell_o.hflip      = spr_i.hflip;
  end

endmodule
